// ----- hw/rtl/http_chunk_deframer_macros.svh -----
// Assertion helpers for the chunk deframer, clocked on aclk and off during reset.
`ifndef HTTP_CHUNK_DEFRAMER_MACROS_SVH
`define HTTP_CHUNK_DEFRAMER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

    localparam int unsigned LINE_BYTES_DEF = 32;
    localparam int unsigned SIZE_W         = 27;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned TDATA_W        = 40;

    localparam logic [SIZE_W-1:0] MAX_CHUNK = SIZE_W'(64 * 1024 * 1024);

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef enum logic [STATUS_W-1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_BIG  = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            r.value = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            r.value = 4'(c - 8'h37);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_chunk_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input beat yields its result beat on m_* in the cycle after it is accepted.
// One byte per cycle unless m_* stalls; parsing is a single pass into the output register.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous): parser back to the size line, errors cleared,
// chunk_limit back to 2^26, output register emptied.

module http_chunk_deframer #(
    parameter int unsigned LINE_BYTES = hcd_pkg::LINE_BYTES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // APB configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // input stream; tdata: in_byte[7:0]
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,
    // result stream; tdata: out_byte[7:0], status[9:8], chunk_length[36:10],
    // last_chunk[37], zero[39:38]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [hcd_pkg::TDATA_W-1:0]  m_tdata,
    // tuser: payload_valid[0]
    output logic                              m_tuser
);
    import hcd_pkg::*;

    localparam int unsigned LCW = $clog2(LINE_BYTES + 1);

    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_ERR   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        HX_START = 3'd0,
        HX_SIGN  = 3'd1,
        HX_ZERO  = 3'd2,
        HX_X     = 3'd3,
        HX_DIG   = 3'd4,
        HX_NODIG = 3'd5,
        HX_DONE  = 3'd6
    } hex_t;

    typedef enum logic [1:0] {
        TR_START   = 2'd0,
        TR_CR      = 2'd1,
        TR_BODY    = 2'd2,
        TR_BODY_CR = 2'd3
    } trail_t;

    phase_t             phase_reg, phase_next;
    hex_t               hex_reg, hex_next;
    trail_t             trail_reg, trail_next;
    logic [LCW-1:0]     line_count_reg, line_count_next;
    logic               cr_reg, cr_next;
    logic [SIZE_W-1:0]  accum_reg, accum_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [SIZE_W-1:0]  done_reg, done_next;
    status_t            err_reg, err_next;
    logic [SIZE_W-1:0]  limit_reg;

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    logic               s_fire;
    logic               cfg_write;
    hex_digit_t         dig;
    logic [SIZE_W+3:0]  shifted;
    logic               take_digit;
    logic               sign_like;
    logic [SIZE_W:0]    done_inc;
    logic [SIZE_W:0]    data_end;

    logic [7:0]         ob;
    logic               pv;
    status_t            st;
    logic [SIZE_W-1:0]  len;
    logic               last;

    logic               err_beat_ok;
    logic               data_beat_ok;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == 1'b0) ? {{(32 - SIZE_W){1'b0}}, limit_reg} : 32'd0;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign dig      = hex_decode(s_tdata);
    assign shifted  = {accum_reg, 4'd0} + {{SIZE_W{1'b0}}, dig.value};
    assign done_inc = {1'b0, done_reg} + (SIZE_W + 1)'(1);
    assign data_end = {1'b0, accum_reg} + (SIZE_W + 1)'(2);

    always_comb begin
        phase_next      = phase_reg;
        hex_next        = hex_reg;
        trail_next      = trail_reg;
        line_count_next = line_count_reg;
        cr_next         = cr_reg;
        accum_next      = accum_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        done_next       = done_reg;
        err_next        = err_reg;
        ob              = 8'd0;
        pv              = 1'b0;
        st              = ST_MORE;
        len             = '0;
        last            = 1'b0;
        take_digit      = 1'b0;
        sign_like       = 1'b0;

        case (phase_reg)
            PH_LINE: begin
                if (line_count_reg < LCW'(LINE_BYTES)) begin
                    line_count_next = line_count_reg + LCW'(1);
                end
                if (cr_reg) begin
                    if (s_tdata != CH_LF) begin
                        phase_next = PH_ERR;
                        err_next   = ST_BAD;
                    end else if (hex_reg inside {HX_START, HX_SIGN, HX_NODIG}) begin
                        phase_next = PH_ERR;
                        err_next   = ST_BAD;
                    end else if (ovf_reg || (neg_reg && accum_reg != '0)
                                 || accum_reg > MAX_CHUNK || accum_reg > limit_reg) begin
                        phase_next = PH_ERR;
                        err_next   = ST_BIG;
                    end else begin
                        len        = accum_reg;
                        last       = (accum_reg == '0);
                        phase_next = last ? PH_TRAIL : PH_DATA;
                        done_next  = '0;
                        trail_next = TR_START;
                    end
                end else begin
                    if (s_tdata == CH_CR) begin
                        cr_next = 1'b1;
                    end else begin
                        case (hex_reg)
                            HX_START: begin
                                if (is_blank(s_tdata)) begin
                                    hex_next = HX_START;
                                end else if (s_tdata == CH_PLUS || s_tdata == CH_MINUS) begin
                                    neg_next = (s_tdata == CH_MINUS);
                                    hex_next = HX_SIGN;
                                end else begin
                                    sign_like = 1'b1;
                                end
                            end
                            HX_SIGN: sign_like = 1'b1;
                            HX_ZERO: begin
                                if (s_tdata == CH_LOW_X || s_tdata == CH_UP_X) begin
                                    hex_next = HX_X;
                                end else if (dig.valid) begin
                                    take_digit = 1'b1;
                                end else begin
                                    hex_next = HX_DONE;
                                end
                            end
                            HX_X, HX_DIG: begin
                                if (dig.valid) begin
                                    take_digit = 1'b1;
                                end else begin
                                    hex_next = HX_DONE;
                                end
                            end
                            default: hex_next = hex_reg;
                        endcase
                        if (sign_like) begin
                            if (s_tdata == CH_ZERO) begin
                                hex_next = HX_ZERO;
                            end else if (dig.valid) begin
                                take_digit = 1'b1;
                            end else begin
                                hex_next = HX_NODIG;
                            end
                        end
                        if (take_digit) begin
                            hex_next = HX_DIG;
                            if (!ovf_reg) begin
                                if (shifted > {4'd0, MAX_CHUNK}) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    accum_next = shifted[SIZE_W-1:0];
                                end
                            end
                        end
                    end
                    if (line_count_reg >= LCW'(LINE_BYTES - 1)) begin
                        phase_next = PH_ERR;
                        err_next   = ST_BAD;
                    end
                end
            end
            PH_DATA: begin
                len = accum_reg;
                if (done_reg < accum_reg) begin
                    pv = 1'b1;
                    ob = s_tdata;
                end
                done_next = done_inc[SIZE_W-1:0];
                if (done_inc >= data_end) begin
                    st         = ST_DONE;
                    phase_next = PH_LINE;
                end
            end
            PH_TRAIL: begin
                last = 1'b1;
                case (trail_reg)
                    TR_START: trail_next = (s_tdata == CH_CR) ? TR_CR : TR_BODY;
                    TR_CR: begin
                        if (s_tdata == CH_LF) begin
                            st         = ST_DONE;
                            phase_next = PH_LINE;
                        end else begin
                            phase_next = PH_ERR;
                            err_next   = ST_BAD;
                        end
                    end
                    TR_BODY: begin
                        if (s_tdata == CH_CR) begin
                            trail_next = TR_BODY_CR;
                        end
                    end
                    default: begin
                        if (s_tdata == CH_LF) begin
                            trail_next = TR_START;
                        end else begin
                            phase_next = PH_ERR;
                            err_next   = ST_BAD;
                        end
                    end
                endcase
            end
            default: phase_next = PH_ERR;
        endcase

        // clear the line parser once a chunk completes
        if (st == ST_DONE) begin
            line_count_next = '0;
            cr_next         = 1'b0;
            hex_next        = HX_START;
            accum_next      = '0;
            ovf_next        = 1'b0;
            neg_next        = 1'b0;
            done_next       = '0;
            trail_next      = TR_START;
        end

        if (phase_next == PH_ERR) begin
            ob   = 8'd0;
            pv   = 1'b0;
            len  = '0;
            last = 1'b0;
            st   = err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LINE;
            hex_reg        <= HX_START;
            trail_reg      <= TR_START;
            line_count_reg <= '0;
            cr_reg         <= 1'b0;
            accum_reg      <= '0;
            ovf_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            done_reg       <= '0;
            err_reg        <= ST_MORE;
            limit_reg      <= MAX_CHUNK;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == 1'b0) begin
                limit_reg <= pwdata[SIZE_W-1:0];
            end
            if (s_fire) begin
                phase_reg      <= phase_next;
                hex_reg        <= hex_next;
                trail_reg      <= trail_next;
                line_count_reg <= line_count_next;
                cr_reg         <= cr_next;
                accum_reg      <= accum_next;
                ovf_reg        <= ovf_next;
                neg_reg        <= neg_next;
                done_reg       <= done_next;
                err_reg        <= err_next;
                m_tvalid_reg   <= 1'b1;
                m_tdata_reg    <= {2'b00, last, len, st, ob};
                m_tuser_reg    <= pv;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign err_beat_ok  = (m_tdata[37:8] == {28'd0, err_reg}) && !m_tuser;
    assign data_beat_ok = (m_tdata[36:10] != '0) && !m_tdata[37];

`include "http_chunk_deframer_macros.svh"

    `HCD_ASSERT_NEXT(a_err_sticky, phase_reg == PH_ERR, phase_reg == PH_ERR, "error phase left")
    `HCD_ASSERT_NEXT(a_err_result, s_fire && phase_reg == PH_ERR, err_beat_ok, "bad error beat")
    `HCD_ASSERT_NOW(a_payload_len, m_tvalid && m_tuser, data_beat_ok, "payload without size")
    `HCD_ASSERT_NOW(a_line_count, 1'b1, line_count_reg <= LCW'(LINE_BYTES), "line count overran")

endmodule

`default_nettype wire

// ----- verif/http_chunk_deframer_tb.sv -----
`timescale 1ns / 1ps

module http_chunk_deframer_tb;
    import hcd_pkg::*;

    localparam int LINE_LEN       = LINE_BYTES_DEF;
    localparam int QUIET_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 300;

    localparam logic [2:0] ADDR_CHUNK_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_SPARE       = 3'd4;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_TRAILER,
        PH_ERROR
    } parse_phase_t;

    typedef enum logic [2:0] {
        HS_START,
        HS_SIGN,
        HS_ZERO,
        HS_X,
        HS_DIGITS,
        HS_NODIGIT,
        HS_END
    } hex_step_t;

    typedef enum logic [1:0] {
        TR_LINE_START,
        TR_EMPTY_CR,
        TR_TEXT,
        TR_TEXT_CR
    } trailer_step_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        payload;
        status_t     status;
        logic [26:0] length;
        logic        last;
    } deframe_out_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    http_chunk_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [26:0]   cfg_limit  = MAX_CHUNK;
    parse_phase_t  p_phase    = PH_SIZE;
    logic [5:0]    p_line_len = '0;
    logic          p_cr       = 1'b0;
    hex_step_t     p_hex      = HS_START;
    logic [26:0]   p_size     = '0;
    logic          p_ovf      = 1'b0;
    logic [27:0]   p_done     = '0;
    trailer_step_t p_trail    = TR_LINE_START;
    logic          p_neg      = 1'b0;
    status_t       p_err      = ST_MORE;

    logic [7:0]    byte_feed [$];
    deframe_out_t  deframed_q [$];
    int unsigned   bytes_queued   = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            rx_hold_ask    = 0;
    int            rx_hold_seen   = 0;
    int            rx_hold_left   = 0;
    int            mismatches     = 0;
    int            quiet_cycles   = 0;

    logic [7:0] blanks [5]   = '{CH_SPACE, 8'h09, CH_LF, 8'h0b, 8'h0c};
    logic [7:0] ext_lead [4] = '{8'h3b, CH_SPACE, 8'h09, 8'h7a};

    function automatic void clear_line();
        p_line_len = '0;
        p_cr       = 1'b0;
        p_hex      = HS_START;
        p_size     = '0;
        p_ovf      = 1'b0;
        p_neg      = 1'b0;
        p_done     = '0;
        p_trail    = TR_LINE_START;
    endfunction

    function automatic void enter_error(input status_t code);
        p_phase = PH_ERROR;
        p_err   = code;
    endfunction

    // saturate: once past 2^26 the value is dead
    function automatic void grow_size(input logic [3:0] d);
        logic [31:0] grown;
        if (p_ovf) return;
        grown = {1'b0, p_size, 4'h0} + {28'd0, d};
        if (grown > {5'd0, MAX_CHUNK}) p_ovf = 1'b1;
        else p_size = grown[26:0];
    endfunction

    function automatic deframe_out_t deframe_byte(input logic [7:0] c);
        deframe_out_t r;
        logic [5:0]   pos;
        logic         hex_ok;
        logic [3:0]   nib;
        logic         start_blank;
        r = '{data: 8'h00, payload: 1'b0, status: ST_MORE, length: '0, last: 1'b0};
        hex_ok = 1'b1;
        nib    = 4'h0;
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
        else hex_ok = 1'b0;
        start_blank = (p_hex == HS_START) && (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d));

        case (p_phase)
            PH_SIZE: begin
                pos = p_line_len;
                if (p_line_len < LINE_LEN) p_line_len++;
                if (p_cr) begin
                    if (c != CH_LF) begin
                        enter_error(ST_BAD);
                    end else if (p_hex inside {HS_START, HS_SIGN, HS_NODIGIT}) begin
                        enter_error(ST_BAD);
                    end else if (p_ovf || (p_neg && p_size != 0) || p_size > MAX_CHUNK ||
                                 p_size > cfg_limit) begin
                        enter_error(ST_BIG);
                    end else begin
                        r.length = p_size;
                        r.last   = (p_size == 0);
                        p_phase  = r.last ? PH_TRAILER : PH_DATA;
                        p_done   = '0;
                        p_trail  = TR_LINE_START;
                    end
                end else begin
                    if (c == CH_CR) begin
                        p_cr = 1'b1;
                    end else if (p_hex == HS_START && (c == CH_PLUS || c == CH_MINUS)) begin
                        p_neg = (c == CH_MINUS);
                        p_hex = HS_SIGN;
                    end else if (!start_blank && (p_hex == HS_START || p_hex == HS_SIGN)) begin
                        if (c == CH_ZERO) begin
                            p_hex = HS_ZERO;
                        end else if (hex_ok) begin
                            grow_size(nib);
                            p_hex = HS_DIGITS;
                        end else begin
                            p_hex = HS_NODIGIT;
                        end
                    end else if (p_hex == HS_ZERO && (c == CH_LOW_X || c == CH_UP_X)) begin
                        p_hex = HS_X;
                    end else if (p_hex inside {HS_ZERO, HS_X, HS_DIGITS}) begin
                        if (hex_ok) begin
                            grow_size(nib);
                            p_hex = HS_DIGITS;
                        end else begin
                            p_hex = HS_END;
                        end
                    end
                    if (pos >= LINE_LEN - 1) enter_error(ST_BAD);
                end
            end
            PH_DATA: begin
                r.length = p_size;
                if (p_done < {1'b0, p_size}) begin
                    r.payload = 1'b1;
                    r.data    = c;
                end
                p_done++;
                if (p_done >= {1'b0, p_size} + 28'd2) begin
                    r.status = ST_DONE;
                    p_phase  = PH_SIZE;
                    clear_line();
                end
            end
            PH_TRAILER: begin
                r.last = 1'b1;
                case (p_trail)
                    TR_LINE_START: p_trail = (c == CH_CR) ? TR_EMPTY_CR : TR_TEXT;
                    TR_EMPTY_CR: begin
                        if (c == CH_LF) begin
                            r.status = ST_DONE;
                            p_phase  = PH_SIZE;
                            clear_line();
                        end else begin
                            enter_error(ST_BAD);
                        end
                    end
                    TR_TEXT: if (c == CH_CR) p_trail = TR_TEXT_CR;
                    default: begin
                        if (c == CH_LF) p_trail = TR_LINE_START;
                        else enter_error(ST_BAD);
                    end
                endcase
            end
            default: ;
        endcase

        if (p_phase == PH_ERROR)
            r = '{data: 8'h00, payload: 1'b0, status: p_err, length: '0, last: 1'b0};
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] rand_not_cr();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_CR);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_feed.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_size_line(input int unsigned sz);
        string       digits;
        int unsigned used;
        bit          has_x;
        bit          fill;
        logic [7:0]  ch;
        used = 0;
        repeat ($urandom_range(0, 2)) begin
            push_byte(blanks[$urandom_range(0, 4)]);
            used++;
        end
        if ($urandom_range(0, 9) == 0) begin
            push_byte(CH_PLUS);
            used++;
        end else if (sz == 0 && $urandom_range(0, 2) == 0) begin
            push_byte(CH_MINUS);
            used++;
        end
        has_x = ($urandom_range(0, 3) == 0);
        if (has_x) begin
            push_byte(CH_ZERO);
            push_byte($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
            used += 2;
        end
        digits = $sformatf("%0h", sz);
        if (has_x && sz == 0 && $urandom_range(0, 1)) digits = "";
        else repeat ($urandom_range(0, 2)) digits = {"0", digits};
        for (int i = 0; i < digits.len(); i++) begin
            ch = digits[i];
            if (ch >= "a" && $urandom_range(0, 1)) ch = ch - 8'h20;
            push_byte(ch);
            used++;
        end
        // fill the line to exactly LINE_LEN bytes now and then
        fill = ($urandom_range(0, 24) == 0);
        if (fill || $urandom_range(0, 3) == 0) begin
            push_byte(ext_lead[$urandom_range(0, 3)]);
            used++;
            repeat ($urandom_range(0, 6)) begin
                push_byte(rand_not_cr());
                used++;
            end
            while (fill && used < LINE_LEN - 2) begin
                push_byte(rand_not_cr());
                used++;
            end
        end
        push_crlf();
    endtask

    task automatic push_body(input int unsigned sz);
        repeat (sz) push_byte(8'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            push_byte(8'($urandom));
            push_byte(8'($urandom));
        end else begin
            push_crlf();
        end
    endtask

    task automatic push_chunk(input int unsigned sz);
        push_size_line(sz);
        if (sz != 0) begin
            push_body(sz);
        end else begin
            repeat ($urandom_range(0, 2)) begin
                repeat ($urandom_range(1, 8)) push_byte(rand_not_cr());
                push_crlf();
            end
            push_crlf();
        end
    endtask

    task automatic push_random_chunks(input int unsigned n);
        int unsigned start;
        int unsigned cap;
        int unsigned sz;
        int unsigned pick;
        start = bytes_queued;
        while (bytes_queued - start < n) begin
            cap  = (cfg_limit < 40) ? cfg_limit : 40;
            pick = $urandom_range(0, 99);
            if (cap == 0 || pick < 15) sz = 0;
            else if (pick < 25) sz = cap;
            else if (pick < 28 && cfg_limit >= 200) sz = $urandom_range(100, 200);
            else sz = $urandom_range(1, cap);
            push_chunk(sz);
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CHUNK_LIMIT) cfg_limit = data[26:0];
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || deframed_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                deframed_q.push_back(deframe_byte(s_tdata));
                offer = 1'b0;
            end
            if (!offer && byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata <= byte_feed.pop_front();
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    always @(posedge aclk) begin : watch_results
        deframe_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata %0h", m_tdata);
                    mismatches++;
                end else begin
                    want = deframed_q.pop_front();
                    check_field("out_byte", want.data, m_tdata[7:0]);
                    check_field("payload_valid", want.payload, m_tuser);
                    check_field("status", want.status, m_tdata[9:8]);
                    check_field("chunk_length", want.length, m_tdata[36:10]);
                    check_field("last_chunk", want.last, m_tdata[37]);
                    check_field("tdata_pad", 32'd0, m_tdata[39:38]);
                end
            end
            if (rx_hold_ask != rx_hold_seen) begin
                rx_hold_seen = rx_hold_ask;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned lim;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme payload byte, prefixed size with extension, signed zero with a trailer
        push_text("1");
        push_crlf();
        push_byte(8'hff);
        push_crlf();
        push_byte(8'h09);
        push_text("+0X2;x");
        push_crlf();
        push_byte(8'h00);
        push_byte(8'h80);
        push_text("zz");
        push_text("-0");
        push_crlf();
        push_text("a:");
        push_crlf();
        push_crlf();
        push_random_chunks(200);
        drain();

        write_reg(ADDR_CHUNK_LIMIT, 32'hffff_ffff);
        send_idle_pct = 69;
        push_random_chunks(250);
        drain();

        write_reg(ADDR_CHUNK_LIMIT, 32'd0);
        write_reg(ADDR_SPARE, $urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        push_random_chunks(150);
        drain();

        write_reg(ADDR_CHUNK_LIMIT, 32'(MAX_CHUNK));
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        // hold off the result side while the sender keeps offering
        rx_hold_ask++;
        push_random_chunks(250);
        drain();

        lim = $urandom_range(5, 40);
        write_reg(ADDR_CHUNK_LIMIT, {5'($urandom), 27'(lim)});
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // pause the sender mid-chunk until every result is in
        push_size_line(lim);
        drain();
        push_body(lim);
        push_random_chunks(250);

        // one broken line, then noise on the sticky error
        case ($urandom_range(0, 7))
            0: repeat (LINE_LEN + 1) push_byte("7");
            1: begin
                push_text("5");
                push_byte(CH_CR);
                push_byte("5");
            end
            2: begin
                push_text("0");
                push_crlf();
                push_text("k:v");
                push_byte(CH_CR);
                push_byte(CH_CR);
            end
            3: begin
                push_text(";ext");
                push_crlf();
            end
            4: begin
                push_text("-1f");
                push_crlf();
            end
            5: begin
                push_text("4000001");
                push_crlf();
            end
            6: begin
                push_text($sformatf("%0h", {1'b0, cfg_limit} + 28'd1));
                push_crlf();
            end
            default: begin
                push_text("fffffffffff");
                push_crlf();
            end
        endcase
        repeat (40) push_byte(8'($urandom));
        drain();

        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
